/* rtl/adrt_pkg.sv */
// adrt_pkg: shared types, constants and opcodes for the audio dma ring tracker
// no dependencies; used by the channel interfaces and the tracker module
`default_nettype none

package adrt_pkg;

    // ring geometry; slot size is a power of two so slot math is shift and mask
    localparam int RING_SLOTS      = 32;
    localparam int SLOT_FRAMES_LG2 = 9;
    localparam int SLOT_FRAMES     = 1 << SLOT_FRAMES_LG2;

    localparam int IDX_W = $clog2(RING_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int OFS_W = SLOT_FRAMES_LG2;
    localparam int POS_W = CNT_W + SLOT_FRAMES_LG2 + 1;

    // command opcodes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_QUERY = 3'd1;
    localparam logic [2:0] OP_OPEN  = 3'd2;
    localparam logic [2:0] OP_CLOSE = 3'd3;
    localparam logic [2:0] OP_PLAY  = 3'd4;
    localparam logic [2:0] OP_PAUSE = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] frame_count;
        logic        dma_halted;
        logic [4:0]  current_index;
        logic [15:0] samples_left;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] frames_accepted;
        logic [14:0] queued_frames;
        logic        lvi_write;
        logic [4:0]  last_valid_index;
        logic        run_write;
        logic        run_value;
        logic [63:0] total_frames;
    } res_item_t;

endpackage

`default_nettype wire

/* rtl/adrt_cmd_if.sv */
// adrt_cmd_if: valid/ready channel carrying one command beat
// depends on adrt_pkg for the payload type
`default_nettype none

interface adrt_cmd_if import adrt_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/adrt_res_if.sv */
// adrt_res_if: valid/ready channel carrying one result beat
// depends on adrt_pkg for the payload type
`default_nettype none

interface adrt_res_if import adrt_pkg::*; ();
    logic      valid;
    logic      ready;
    res_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/audio_dma_ring_tracker.sv */
// audio_dma_ring_tracker: producer-side accounting for a 32-slot audio dma ring
// depends on adrt_pkg, adrt_cmd_if and adrt_res_if
//
// Each command beat is captured in an input register, evaluated by one pass of
// short logic against the ring state, and lands in the result register, where
// the sink takes it. One beat is taken every cycle as long as the result side
// keeps draining; the result register lets a new command enter while the
// previous result waits. A write beat reclaims played slots, then takes up to
// the free frame space in closed form and publishes completed slots through the
// last valid index. Every command yields exactly one result beat.
`default_nettype none

module audio_dma_ring_tracker import adrt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    adrt_cmd_if.sink     cmd,
    adrt_res_if.source   res
);

    // input register
    logic             s1_valid_reg;
    cmd_item_t        s1_item_reg;
    logic             s1_fire;

    // ring state
    logic             ring_open_reg,  ring_open_next;
    logic             running_reg,    running_next;
    logic [IDX_W-1:0] fill_slot_reg,  fill_slot_next;
    logic [OFS_W-1:0] fill_offset_reg, fill_offset_next;
    logic [CNT_W-1:0] in_flight_reg,  in_flight_next;
    logic [IDX_W-1:0] seen_index_reg, seen_index_next;
    logic [63:0]      frames_total_reg, frames_total_next;

    // result register
    logic             out_valid_reg;
    res_item_t        out_item_reg;
    res_item_t        out_item_next;

    // reclaim and write datapath
    logic [IDX_W-1:0] step;
    logic [CNT_W-1:0] step_clamped;
    logic [CNT_W-1:0] flight_rc;
    logic [IDX_W-1:0] seen_rc;
    logic [CNT_W:0]   claimed;
    logic [POS_W-1:0] capacity;
    logic [15:0]      accepted;
    logic [POS_W-1:0] new_pos;
    logic [CNT_W-1:0] done_slots;

    // query datapath
    logic [POS_W-1:0] queued_full;
    logic [14:0]      half_left;
    logic [POS_W-1:0] played;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || s1_fire;
    assign res.valid = out_valid_reg;
    assign res.item  = out_item_reg;

    // reclaim slots the controller has played
    always_comb
    begin
        step = s1_item_reg.current_index - seen_index_reg;
        if ({1'b0, step} > in_flight_reg)
        begin
            step_clamped = in_flight_reg;
        end
        else
        begin
            step_clamped = {1'b0, step};
        end
        if (!running_reg)
        begin
            flight_rc = in_flight_reg;
            seen_rc   = seen_index_reg;
        end
        else if (s1_item_reg.dma_halted)
        begin
            flight_rc = '0;
            seen_rc   = s1_item_reg.current_index;
        end
        else
        begin
            flight_rc = in_flight_reg - step_clamped;
            seen_rc   = s1_item_reg.current_index;
        end
    end

    // free frame space and fill advance after reclaim
    always_comb
    begin
        claimed = {1'b0, flight_rc} + {{CNT_W{1'b0}}, (fill_offset_reg != '0)};
        if (claimed >= (CNT_W+1)'(RING_SLOTS))
        begin
            capacity = '0;
        end
        else
        begin
            capacity = ((POS_W)'(RING_SLOTS) - (POS_W)'(flight_rc)) << SLOT_FRAMES_LG2;
            capacity = capacity - (POS_W)'(fill_offset_reg);
        end
        if ((POS_W)'(s1_item_reg.frame_count) < capacity)
        begin
            accepted = s1_item_reg.frame_count;
        end
        else
        begin
            accepted = capacity[15:0];
        end
        new_pos    = (POS_W)'(fill_offset_reg) + (POS_W)'(accepted);
        done_slots = new_pos[SLOT_FRAMES_LG2 +: CNT_W];
    end

    // queued frames ahead of the playhead
    always_comb
    begin
        queued_full = (POS_W)'(in_flight_reg) << SLOT_FRAMES_LG2;
        half_left   = s1_item_reg.samples_left[15:1];
        if ((POS_W)'(half_left) >= (POS_W)'(SLOT_FRAMES))
        begin
            played = '0;
        end
        else
        begin
            played = (POS_W)'(SLOT_FRAMES) - (POS_W)'(half_left);
        end
    end

    // command decode and next state
    always_comb
    begin
        ring_open_next    = ring_open_reg;
        running_next      = running_reg;
        fill_slot_next    = fill_slot_reg;
        fill_offset_next  = fill_offset_reg;
        in_flight_next    = in_flight_reg;
        seen_index_next   = seen_index_reg;
        frames_total_next = frames_total_reg;
        out_item_next     = '0;

        case (s1_item_reg.opcode)
            OP_WRITE:
            begin
                if (ring_open_reg)
                begin
                    seen_index_next   = seen_rc;
                    in_flight_next    = flight_rc + done_slots;
                    fill_offset_next  = new_pos[OFS_W-1:0];
                    fill_slot_next    = fill_slot_reg + done_slots[IDX_W-1:0];
                    frames_total_next = frames_total_reg + 64'(accepted);
                    out_item_next.frames_accepted = accepted;
                    if (done_slots != '0)
                    begin
                        out_item_next.lvi_write        = 1'b1;
                        out_item_next.last_valid_index =
                            5'(fill_slot_reg + done_slots[IDX_W-1:0] - 1'b1);
                    end
                end
            end
            OP_QUERY:
            begin
                if (ring_open_reg)
                begin
                    if (!running_reg)
                    begin
                        out_item_next.queued_frames = 15'(queued_full);
                    end
                    else if (!s1_item_reg.dma_halted && queued_full > played)
                    begin
                        out_item_next.queued_frames = 15'(queued_full - played);
                    end
                end
            end
            OP_OPEN:
            begin
                ring_open_next    = 1'b1;
                running_next      = 1'b0;
                fill_slot_next    = '0;
                fill_offset_next  = '0;
                in_flight_next    = '0;
                seen_index_next   = '0;
                frames_total_next = '0;
                out_item_next.run_write = 1'b1;
                out_item_next.lvi_write = 1'b1;
            end
            OP_CLOSE:
            begin
                if (ring_open_reg)
                begin
                    ring_open_next = 1'b0;
                    running_next   = 1'b0;
                    in_flight_next = '0;
                    out_item_next.run_write = 1'b1;
                end
            end
            OP_PLAY:
            begin
                if (ring_open_reg && !running_reg)
                begin
                    running_next = 1'b1;
                    out_item_next.run_write = 1'b1;
                    out_item_next.run_value = 1'b1;
                end
            end
            OP_PAUSE:
            begin
                if (ring_open_reg && running_reg)
                begin
                    running_next = 1'b0;
                    out_item_next.run_write = 1'b1;
                end
            end
            default:
            begin
                out_item_next = '0;
            end
        endcase

        out_item_next.total_frames = frames_total_next;
    end

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg <= cmd.item;
        end
    end

    // ring state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_open_reg    <= 1'b0;
            running_reg      <= 1'b0;
            fill_slot_reg    <= '0;
            fill_offset_reg  <= '0;
            in_flight_reg    <= '0;
            seen_index_reg   <= '0;
            frames_total_reg <= '0;
        end
        else if (s1_fire)
        begin
            ring_open_reg    <= ring_open_next;
            running_reg      <= running_next;
            fill_slot_reg    <= fill_slot_next;
            fill_offset_reg  <= fill_offset_next;
            in_flight_reg    <= in_flight_next;
            seen_index_reg   <= seen_index_next;
            frames_total_reg <= frames_total_next;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // occupancy never exceeds the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, in_flight_reg} + {{CNT_W{1'b0}}, (fill_offset_reg != '0)})
            <= (CNT_W+1)'(RING_SLOTS))
        else $error("ring occupancy beyond ring size");

    // the run state only exists on an open ring
    assert property (@(posedge clk) disable iff (!rst_n)
        !ring_open_reg |-> !running_reg)
        else $error("running while ring closed");

    // a delivered beat reports the live running total
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready |-> res.item.total_frames == frames_total_reg)
        else $error("result total out of step with state");

    // a held command is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("pending command lost");

endmodule

`default_nettype wire
